>>> rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg: shared definitions for the linear interpolation resampler
// Field widths, CSR register indexes, reset values and limits used by the
// resampler datapath and its port checker.
// ----------------------------------------------------------------------------
package lirs_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 20;   // signed Q4.16 input sample
   localparam int PCM_W      = 16;   // signed PCM16 result
   localparam int RATE_W     = 19;   // sample rate in Hz
   localparam int COUNT_W    = 24;   // samples per run
   localparam int OUT_IDX_W  = 30;   // output index and total outputs
   localparam int POS_W      = 25;   // integer source position of an output
   localparam int LIMIT_W    = 24;   // upsample limit, input_rate times max ratio
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Shared restoring divider
   localparam int DIV_Q_W    = 45;   // dividend / quotient shift register
   localparam int DIV_R_W    = 20;   // partial remainder and divisor

   // Multiply-accumulate widths
   localparam int MUL_A_W    = 25;
   localparam int MUL_B_W    = 20;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 40;
   localparam int MAG_W      = RATE_W + 16;   // clamp limit output_rate * 65536
   localparam int DVD_W      = MAG_W - 1;     // scaled magnitude fed to divider

   // Limits
   localparam int MAX_UPSAMPLE = 31;
   localparam int MAX_RESULTS  = 64;
   localparam int RES_CNT_W    = 7;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_RATE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_RATE  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = CSR_IDX_W'(2);

   // CSR reset values
   localparam logic [RATE_W-1:0]  INPUT_RATE_RESET   = RATE_W'(24000);
   localparam logic [RATE_W-1:0]  OUTPUT_RATE_RESET  = RATE_W'(16000);
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = COUNT_W'(1);

endpackage

>>> rtl/linear_interp_resampler_pcm16.sv
// Linear interpolation resampler, Q4.16 in, PCM16 out. A run is sample_count
// input requests; it yields round-half-up(sample_count*output_rate/input_rate)
// results (at least one), each emitted as soon as both of its source samples
// have arrived. One input request is worked at a time and req_stall stays high
// until all its results are taken. The first request of a run does run setup
// in the shared restoring divider (45 steps for the output total, 19 for the
// per-output phase step). Every result then passes through the shared
// multiplier (MAC0, MAC1), the clamp and scale (PREP0, PREP1) and 16 divider
// steps for the PCM scaling by output_rate, then waits out any response stall.
// Each request also passes the CHK and DONE bookkeeping states. A CSR write
// (taken only while idle) aborts the current run. When output_rate exceeds 31
// times input_rate, every request returns one result with rate_error set.
// ----------------------------------------------------------------------------
// linear_interp_resampler_pcm16: sample rate converter top level
// Sequencer around one shared restoring divider and one shared multiplier.
// ----------------------------------------------------------------------------
module linear_interp_resampler_pcm16 (
   input  logic                                   clock,
   input  logic                                   reset,
   // input requests
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0]   req_sample_in,
   // results
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lirs_pkg::PCM_W-1:0]      rsp_pcm_out,
   output logic                                   rsp_run_last,
   output logic                                   rsp_stream_end,
   output logic                                   rsp_rate_error,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lirs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lirs_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int SW  = lirs_pkg::SAMPLE_W;
   localparam int RW  = lirs_pkg::RATE_W;
   localparam int CW  = lirs_pkg::COUNT_W;
   localparam int OW  = lirs_pkg::OUT_IDX_W;
   localparam int PW  = lirs_pkg::POS_W;
   localparam int QW  = lirs_pkg::DIV_Q_W;
   localparam int DW  = lirs_pkg::DIV_R_W;
   localparam int AW  = lirs_pkg::ACC_W;
   localparam int MW  = lirs_pkg::MAG_W;
   localparam int VW  = lirs_pkg::DVD_W;
   localparam int NW  = lirs_pkg::RES_CNT_W;
   localparam int PCW = lirs_pkg::PCM_W;

   // divider step counts
   localparam logic [5:0] TOTAL_STEPS = 6'(QW);
   localparam logic [5:0] PHASE_STEPS = 6'(RW);
   localparam logic [5:0] PCM_STEPS   = 6'(PCW);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MULN  = 4'd1;
   localparam logic [3:0] ST_LDT   = 4'd2;
   localparam logic [3:0] ST_DIVT  = 4'd3;
   localparam logic [3:0] ST_TSET  = 4'd4;
   localparam logic [3:0] ST_DIVS  = 4'd5;
   localparam logic [3:0] ST_SSET  = 4'd6;
   localparam logic [3:0] ST_CHK   = 4'd7;
   localparam logic [3:0] ST_MAC0  = 4'd8;
   localparam logic [3:0] ST_MAC1  = 4'd9;
   localparam logic [3:0] ST_PREP0 = 4'd10;
   localparam logic [3:0] ST_PREP1 = 4'd11;
   localparam logic [3:0] ST_DIVP  = 4'd12;
   localparam logic [3:0] ST_FIN   = 4'd13;
   localparam logic [3:0] ST_OUT   = 4'd14;
   localparam logic [3:0] ST_DONE  = 4'd15;

   // control registers
   logic [3:0]           state_ff, state_in;
   logic [RW-1:0]        input_rate_ff, input_rate_in;
   logic [RW-1:0]        output_rate_ff, output_rate_in;
   logic [CW-1:0]        sample_count_ff, sample_count_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic [CW-1:0]        in_idx_ff, in_idx_in;
   logic [OW-1:0]        out_idx_ff, out_idx_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [PW-1:0]        k_ff, k_in;
   logic [OW-1:0]        total_ff, total_in;
   logic [5:0]           step_ff, step_in;
   logic [NW-1:0]        res_cnt_ff, res_cnt_in;

   // payload registers
   logic signed [SW-1:0] cur_ff, cur_in;
   logic [MW+8-1:0]      prod_ff, prod_in;
   logic [DW-1:0]        div_r_ff, div_r_in;
   logic [QW-1:0]        div_q_ff, div_q_in;
   logic [DW-1:0]        div_d_ff, div_d_in;
   logic [RW-1:0]        q_step_ff, q_step_in;
   logic [RW-1:0]        r_step_ff, r_step_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [MW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [PCW-1:0]       pcm_ff, pcm_in;
   logic                 run_last_ff, run_last_in;
   logic                 stream_end_ff, stream_end_in;
   logic                 rate_error_ff, rate_error_in;

   // effective configuration, zero read as one
   logic [RW-1:0]                    irate, orate;
   logic [CW-1:0]                    n_eff;
   logic [lirs_pkg::LIMIT_W-1:0]     up_limit;
   logic                             rate_err;

   assign irate    = (input_rate_ff == '0)   ? RW'(1) : input_rate_ff;
   assign orate    = (output_rate_ff == '0)  ? RW'(1) : output_rate_ff;
   assign n_eff    = (sample_count_ff == '0) ? CW'(1) : sample_count_ff;
   assign up_limit = lirs_pkg::LIMIT_W'(irate) * lirs_pkg::LIMIT_W'(lirs_pkg::MAX_UPSAMPLE);
   assign rate_err = lirs_pkg::LIMIT_W'(orate) > up_limit;

   // run position of the current request
   logic          last_in_run;
   logic          k_before_j;
   logic          more_due;
   logic [SW-1:0] s0;

   assign last_in_run = ({1'b0, in_idx_ff} + PW'(1)) >= {1'b0, n_eff};
   assign k_before_j  = k_ff < {1'b0, in_idx_ff};
   assign more_due    = (out_idx_ff < total_ff) && (last_in_run || k_before_j)
                        && (res_cnt_ff < NW'(lirs_pkg::MAX_RESULTS));
   assign s0          = k_before_j ? prev_ff : cur_ff;

   // shared restoring divider step
   logic [DW:0]   div_shift;
   logic [DW:0]   div_diff;
   logic          div_ge;
   logic [DW-1:0] div_r_step;
   logic [QW-1:0] div_q_step;

   assign div_shift  = {div_r_ff, div_q_ff[QW-1]};
   assign div_diff   = div_shift - {1'b0, div_d_ff};
   assign div_ge     = div_shift >= {1'b0, div_d_ff};
   assign div_r_step = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
   assign div_q_step = {div_q_ff[QW-2:0], div_ge};

   // shared multiplier
   logic signed [lirs_pkg::MUL_A_W-1:0] mul_a;
   logic signed [lirs_pkg::MUL_B_W-1:0] mul_b;
   logic signed [lirs_pkg::MUL_P_W-1:0] mul_p;

   always_comb begin
      case (state_ff)
         ST_MULN: begin
            mul_a = {1'b0, n_eff};
            mul_b = {1'b0, orate};
         end
         ST_MAC0: begin
            mul_a = {{(lirs_pkg::MUL_A_W-SW){s0[SW-1]}}, s0};
            mul_b = {1'b0, orate - rem_ff};
         end
         default: begin
            mul_a = {{(lirs_pkg::MUL_A_W-SW){cur_ff[SW-1]}}, cur_ff};
            mul_b = {1'b0, rem_ff};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // phase advance by one output
   logic [RW:0] rem_sum;
   logic [RW:0] rem_wrap;
   logic        wrap;

   assign rem_sum  = {1'b0, rem_ff} + {1'b0, r_step_ff};
   assign rem_wrap = rem_sum - {1'b0, orate};
   assign wrap     = rem_sum >= {1'b0, orate};

   // clamp and scale
   logic [AW-1:0]      acc_abs;
   logic [MW-1:0]      full_scale;
   logic [MW+15-1:0]   pos_scaled;
   logic [VW-1:0]      dividend;

   assign acc_abs    = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign full_scale = {orate, 16'b0};
   // times 32767 as a shift and subtract
   assign pos_scaled = {mag_ff, 15'b0} - {15'b0, mag_ff};
   assign dividend   = neg_ff ? mag_ff[MW-1:1] : pos_scaled[MW+15-1:16];

   logic csr_write;
   logic req_take;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_write = csr_valid && csr_ready;
   assign req_take  = req_valid && !req_stall;

   // sequencer and datapath next state
   always_comb begin
      state_in        = state_ff;
      input_rate_in   = input_rate_ff;
      output_rate_in  = output_rate_ff;
      sample_count_in = sample_count_ff;
      prev_in         = prev_ff;
      in_idx_in       = in_idx_ff;
      out_idx_in      = out_idx_ff;
      rem_in          = rem_ff;
      k_in            = k_ff;
      total_in        = total_ff;
      step_in         = step_ff;
      res_cnt_in      = res_cnt_ff;
      cur_in          = cur_ff;
      prod_in         = prod_ff;
      div_r_in        = div_r_ff;
      div_q_in        = div_q_ff;
      div_d_in        = div_d_ff;
      q_step_in       = q_step_ff;
      r_step_in       = r_step_ff;
      acc_in          = acc_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      pcm_in          = pcm_ff;
      run_last_in     = run_last_ff;
      stream_end_in   = stream_end_ff;
      rate_error_in   = rate_error_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               // write a register and abort the run
               case (csr_index)
                  lirs_pkg::CSR_INPUT_RATE: begin
                     input_rate_in = csr_data[RW-1:0];
                  end
                  lirs_pkg::CSR_OUTPUT_RATE: begin
                     output_rate_in = csr_data[RW-1:0];
                  end
                  lirs_pkg::CSR_SAMPLE_COUNT: begin
                     sample_count_in = csr_data[CW-1:0];
                  end
                  default: begin
                  end
               endcase
               if (csr_index == lirs_pkg::CSR_INPUT_RATE ||
                   csr_index == lirs_pkg::CSR_OUTPUT_RATE ||
                   csr_index == lirs_pkg::CSR_SAMPLE_COUNT) begin
                  in_idx_in  = '0;
                  out_idx_in = '0;
                  rem_in     = '0;
                  k_in       = '0;
               end
            end else if (req_take) begin
               cur_in     = req_sample_in;
               res_cnt_in = '0;
               state_in   = (in_idx_ff == '0) ? ST_MULN : ST_CHK;
            end
         end
         ST_MULN: begin
            prod_in  = mul_p[MW+8-1:0];
            state_in = ST_LDT;
         end
         ST_LDT: begin
            // total = (2*n*orate + irate) / (2*irate)
            div_r_in = '0;
            div_q_in = QW'({prod_ff, 1'b0}) + QW'(irate);
            div_d_in = {irate, 1'b0};
            step_in  = TOTAL_STEPS;
            state_in = ST_DIVT;
         end
         ST_DIVT: begin
            div_r_in = div_r_step;
            div_q_in = div_q_step;
            step_in  = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               state_in = ST_TSET;
            end
         end
         ST_TSET: begin
            total_in = (div_q_ff == '0) ? OW'(1) : div_q_ff[OW-1:0];
            // phase step = irate / orate
            div_r_in = '0;
            div_q_in = {irate, (QW-RW)'(0)};
            div_d_in = DW'(orate);
            step_in  = PHASE_STEPS;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            div_r_in = div_r_step;
            div_q_in = div_q_step;
            step_in  = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               state_in = ST_SSET;
            end
         end
         ST_SSET: begin
            q_step_in  = div_q_ff[RW-1:0];
            r_step_in  = div_r_ff[RW-1:0];
            out_idx_in = '0;
            rem_in     = '0;
            k_in       = '0;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            if (rate_err) begin
               pcm_in        = '0;
               run_last_in   = 1'b1;
               stream_end_in = last_in_run;
               rate_error_in = 1'b1;
               state_in      = ST_OUT;
            end else if (more_due) begin
               state_in = ST_MAC0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MAC0: begin
            acc_in   = mul_p[AW-1:0];
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            acc_in   = acc_ff + mul_p[AW-1:0];
            state_in = ST_PREP0;
         end
         ST_PREP0: begin
            // clamp magnitude, advance to the next output
            neg_in     = acc_ff[AW-1];
            mag_in     = (acc_abs > AW'(full_scale)) ? full_scale : acc_abs[MW-1:0];
            out_idx_in = out_idx_ff + OW'(1);
            rem_in     = wrap ? rem_wrap[RW-1:0] : rem_sum[RW-1:0];
            k_in       = k_ff + PW'(q_step_ff) + PW'(wrap);
            res_cnt_in = res_cnt_ff + NW'(1);
            state_in   = ST_PREP1;
         end
         ST_PREP1: begin
            // high part stays below orate, so 16 quotient bits suffice
            div_r_in = DW'(dividend[VW-1:PCW]);
            div_q_in = {dividend[PCW-1:0], (QW-PCW)'(0)};
            div_d_in = DW'(orate);
            step_in  = PCM_STEPS;
            state_in = ST_DIVP;
         end
         ST_DIVP: begin
            div_r_in = div_r_step;
            div_q_in = div_q_step;
            step_in  = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            pcm_in        = neg_ff ? PCW'(0) - div_q_ff[PCW-1:0] : div_q_ff[PCW-1:0];
            run_last_in   = !more_due;
            stream_end_in = (out_idx_ff == total_ff);
            rate_error_in = 1'b0;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = run_last_ff ? ST_DONE : ST_MAC0;
            end
         end
         ST_DONE: begin
            // retire the request, restart after the last of the run
            prev_in = cur_ff;
            if (last_in_run) begin
               in_idx_in  = '0;
               out_idx_in = '0;
               rem_in     = '0;
               k_in       = '0;
            end else begin
               in_idx_in = in_idx_ff + CW'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         input_rate_ff   <= lirs_pkg::INPUT_RATE_RESET;
         output_rate_ff  <= lirs_pkg::OUTPUT_RATE_RESET;
         sample_count_ff <= lirs_pkg::SAMPLE_COUNT_RESET;
         prev_ff         <= '0;
         in_idx_ff       <= '0;
         out_idx_ff      <= '0;
         rem_ff          <= '0;
         k_ff            <= '0;
         total_ff        <= '0;
         step_ff         <= '0;
         res_cnt_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         input_rate_ff   <= input_rate_in;
         output_rate_ff  <= output_rate_in;
         sample_count_ff <= sample_count_in;
         prev_ff         <= prev_in;
         in_idx_ff       <= in_idx_in;
         out_idx_ff      <= out_idx_in;
         rem_ff          <= rem_in;
         k_ff            <= k_in;
         total_ff        <= total_in;
         step_ff         <= step_in;
         res_cnt_ff      <= res_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prod_ff       <= prod_in;
      div_r_ff      <= div_r_in;
      div_q_ff      <= div_q_in;
      div_d_ff      <= div_d_in;
      q_step_ff     <= q_step_in;
      r_step_ff     <= r_step_in;
      acc_ff        <= acc_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      pcm_ff        <= pcm_in;
      run_last_ff   <= run_last_in;
      stream_end_ff <= stream_end_in;
      rate_error_ff <= rate_error_in;
   end

   // result port
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_pcm_out    = pcm_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_stream_end = stream_end_ff;
   assign rsp_rate_error = rate_error_ff;

endmodule

>>> rtl/lirs_checker.sv
// ----------------------------------------------------------------------------
// lirs_checker: port checker for the linear interpolation resampler
// Watches the top level ports and flags sequencing and result flag slips.
// ----------------------------------------------------------------------------
module lirs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [lirs_pkg::PCM_W-1:0]   rsp_pcm_out,
   input logic                                rsp_run_last,
   input logic                                rsp_stream_end,
   input logic                                rsp_rate_error
);

   // hold off new requests while a result waits
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while a result is pending");

   // an accepted request occupies the block on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready right after taking a request");

   // a rate error result is a single zero result
   a_rate_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_error |-> rsp_run_last && (rsp_pcm_out == '0))
      else $error("rate error result is not a single zero result");

   // the final output of a run closes its request too
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run last");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pcm_out)
                                 && $stable(rsp_run_last))
      else $error("stalled result changed");

endmodule

bind linear_interp_resampler_pcm16 lirs_checker u_lirs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pcm_out    (rsp_pcm_out),
   .rsp_run_last   (rsp_run_last),
   .rsp_stream_end (rsp_stream_end),
   .rsp_rate_error (rsp_rate_error)
);
